// ===== hw/rtl/tgr_pkg.sv =====
`default_nettype none

package tgr_pkg;

    localparam int LINE_WIDTH    = 320;
    localparam int SCREEN_HEIGHT = 200;
    localparam int GLYPH_COUNT   = 224;

    localparam int FONT_DEPTH = GLYPH_COUNT * 8;
    localparam int FONT_AW    = 11;
    localparam int OFF_W      = 21;
    localparam int Y_W        = 12;

    // column at which a printable code wraps to the next row
    localparam int WRAP_LIMIT = (LINE_WIDTH / 8 - 1 > 63) ? 63 : LINE_WIDTH / 8 - 1;

    localparam logic [OFF_W-1:0]   LINE_W_OFF   = OFF_W'(LINE_WIDTH);
    localparam logic [Y_W-1:0]     SCREEN_H_Y   = Y_W'(SCREEN_HEIGHT);
    localparam logic [FONT_AW:0]   FONT_DEPTH_A = (FONT_AW + 1)'(FONT_DEPTH);
    localparam logic [5:0]         WRAP_COL     = 6'(WRAP_LIMIT);
    localparam logic [7:0]         GLYPH_LIMIT  = 8'(GLYPH_COUNT - 1);

    localparam logic [7:0] CODE_NEWLINE    = 8'd10;
    localparam logic [7:0] CODE_PRINTABLE  = 8'd32;
    localparam logic [7:0] ROW_MAX         = 8'd255;
    localparam logic [Y_W-1:0] TOP_MARGIN  = 12'd6;
    localparam logic [OFF_W-1:0] LEFT_EDGE = 21'd8;

    localparam logic REQ_PRINT = 1'b0;
    localparam logic REQ_LOAD  = 1'b1;

    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    localparam logic [7:0] FG_RESET = 8'd0;
    localparam logic [7:0] BG_RESET = 8'd9;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one queued job for the drawing side: a glyph to draw or a font row to store
    typedef struct packed {
        logic               is_load;
        logic [FONT_AW-1:0] addr;
        logic [7:0]         bits;
        logic               glyph_ok;
        logic [OFF_W-1:0]   base_off;
        logic [Y_W-1:0]     base_y;
        logic [7:0]         row;
    } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tgr_front.sv =====
`default_nettype none

module tgr_front
    import tgr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               req_type,
    input  wire logic [7:0]         char_code,
    input  wire logic [FONT_AW-1:0] font_row_addr,
    input  wire logic [7:0]         font_row_bits,
    input  wire logic               q_full,
    output logic                    q_push,
    output cmd_t                    q_cmd
);

    logic [7:0]     cursor_row_reg, cursor_row_next;
    logic [5:0]     cursor_col_reg, cursor_col_next;
    logic           accept;
    logic           wrap;
    logic [7:0]     row_inc;
    logic [7:0]     row_use;
    logic [5:0]     col_use;
    logic [7:0]     glyph;
    logic [Y_W-1:0] base_y;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign row_inc = (cursor_row_reg == ROW_MAX) ? cursor_row_reg : cursor_row_reg + 8'd1;
    assign wrap    = cursor_col_reg >= WRAP_COL;
    assign row_use = wrap ? row_inc : cursor_row_reg;
    assign col_use = wrap ? 6'd0 : cursor_col_reg;
    assign glyph   = char_code - CODE_PRINTABLE;
    assign base_y  = {row_use, 4'b0000} + TOP_MARGIN;

    always_comb
    begin
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        q_push          = 1'b0;

        q_cmd.is_load  = (req_type == REQ_LOAD);
        q_cmd.addr     = (req_type == REQ_LOAD) ? font_row_addr : {glyph[FONT_AW-4:0], 3'b000};
        q_cmd.bits     = font_row_bits;
        q_cmd.glyph_ok = glyph <= GLYPH_LIMIT;
        q_cmd.base_off = OFF_W'(base_y) * LINE_W_OFF + OFF_W'({col_use, 3'b000}) + LEFT_EDGE;
        q_cmd.base_y   = base_y;
        q_cmd.row      = row_use;

        if (accept)
        begin
            if (req_type == REQ_LOAD)
            begin
                // rows beyond the font are dropped
                q_push = {1'b0, font_row_addr} < FONT_DEPTH_A;
            end
            else if (char_code == CODE_NEWLINE)
            begin
                cursor_row_next = row_inc;
                cursor_col_next = 6'd0;
            end
            else if (char_code >= CODE_PRINTABLE)
            begin
                q_push          = 1'b1;
                cursor_row_next = row_use;
                cursor_col_next = col_use + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg <= 8'd0;
            cursor_col_reg <= 6'd0;
        end
        else
        begin
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tgr_queue.sv =====
`default_nettype none

module tgr_queue
    import tgr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output cmd_t      head
);

    cmd_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg,  count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tgr_back.sv =====
`default_nettype none

module tgr_back
    import tgr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  cmd_t                   q_head,
    output logic                   q_pop,
    input  wire logic [7:0]        fg_color,
    input  wire logic [7:0]        bg_color,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [OFF_W-1:0]       pixel_offset,
    output logic [7:0]             pixel_color,
    output logic                   on_screen,
    output logic [7:0]             text_row,
    output logic                   last
);

    logic [7:0]         font_mem [FONT_DEPTH];
    logic [7:0]         rd_data_reg;

    logic [5:0]         cnt_reg, cnt_next;
    logic               advance;
    logic               issue;
    logic               mem_we;
    logic [FONT_AW-1:0] rd_addr;

    logic               s1_valid_reg;
    logic [5:0]         s1_cnt_reg;
    logic               s1_ok_reg;
    logic [OFF_W-1:0]   s1_base_reg;
    logic [Y_W-1:0]     s1_base_y_reg;
    logic [7:0]         s1_row_reg;

    logic               out_valid_reg;
    logic [OFF_W-1:0]   offset_reg;
    logic [7:0]         color_reg;
    logic               on_screen_reg;
    logic [7:0]         row_reg;
    logic               last_reg;

    logic [2:0]         s1_cy;
    logic [2:0]         s1_cx;
    logic               bit_set;
    logic [Y_W-1:0]     pix_y;

    // whole pipeline moves together whenever the output register can take a word
    assign advance = !out_valid_reg || out_ready;
    assign issue   = advance && !q_empty && !q_head.is_load;
    assign mem_we  = advance && !q_empty && q_head.is_load;
    assign q_pop   = mem_we || (issue && cnt_reg == 6'd63);
    assign rd_addr = q_head.addr + FONT_AW'(cnt_reg[5:3]);
    assign cnt_next = issue ? cnt_reg + 6'd1 : cnt_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            font_mem[q_head.addr] <= q_head.bits;
        end
        if (issue)
        begin
            rd_data_reg <= font_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_cnt_reg    <= cnt_reg;
            s1_ok_reg     <= q_head.glyph_ok;
            s1_base_reg   <= q_head.base_off;
            s1_base_y_reg <= q_head.base_y;
            s1_row_reg    <= q_head.row;
        end
    end

    assign s1_cy   = s1_cnt_reg[5:3];
    assign s1_cx   = s1_cnt_reg[2:0];
    assign bit_set = s1_ok_reg && rd_data_reg[s1_cx];
    assign pix_y   = s1_base_y_reg + Y_W'(s1_cy);

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            offset_reg    <= s1_base_reg + OFF_W'(s1_cy) * LINE_W_OFF - OFF_W'(s1_cx);
            color_reg     <= bit_set ? fg_color : bg_color;
            on_screen_reg <= pix_y < SCREEN_H_Y;
            row_reg       <= s1_row_reg;
            last_reg      <= s1_cnt_reg == 6'd63;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= 6'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (advance)
            begin
                s1_valid_reg  <= issue;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_offset = offset_reg;
    assign pixel_color  = color_reg;
    assign on_screen    = on_screen_reg;
    assign text_row     = row_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/text_glyph_rasterizer_top.sv =====
// 8x8 bitmap font text engine: turns a word stream of character codes into pixel writes.
// input channel: req_type selects print (char_code) or font load (font_row_addr,
// font_row_bits); a font load stores one glyph row, a newline moves the cursor to the
// start of the next row, other control codes are dropped, none of these give output.
// output channel: one word per pixel, 64 per printable code, glyph rows top to bottom,
// last marks the 64th pixel; pixel_offset is y*320+x, on_screen flags y below 200.
// config channel: cfg_index 0 is the foreground colour, 1 the background colour;
// write only while no character is in flight. cfg_ready is always high.
// throughput: one pixel per cycle from the drawing pipeline while out_ready is high;
// a font load holds the drawing side only to store its row, newlines and control
// codes never reach it. a code passes the job queue, the font read register and the
// output register before its first pixel leaves. a four-entry job queue sits between
// the cursor logic and the drawing pipeline, so input is taken while pixels go out.
// when out_ready is low and a pixel word waits, the pipeline freezes in place, the
// queue fills and in_ready falls once four jobs are waiting.
// reset: cursor at row 0 column 0, foreground 0, background 9, queue empty; font
// rows hold nothing defined until loaded.
`default_nettype none

module text_glyph_rasterizer_top
    import tgr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               req_type,
    input  wire logic [7:0]         char_code,
    input  wire logic [FONT_AW-1:0] font_row_addr,
    input  wire logic [7:0]         font_row_bits,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [OFF_W-1:0]        pixel_offset,
    output logic [7:0]              pixel_color,
    output logic                    on_screen,
    output logic [7:0]              text_row,
    output logic                    last,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [7:0]         cfg_data
);

    logic [7:0] fg_color_reg;
    logic [7:0] bg_color_reg;
    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    cmd_t       q_cmd;
    cmd_t       q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_color_reg <= FG_RESET;
            bg_color_reg <= BG_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FG:  fg_color_reg <= cfg_data;
                CFG_BG:  bg_color_reg <= cfg_data;
                default: fg_color_reg <= fg_color_reg;
            endcase
        end
    end

    tgr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .char_code     (char_code),
        .font_row_addr (font_row_addr),
        .font_row_bits (font_row_bits),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    tgr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    tgr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .fg_color     (fg_color_reg),
        .bg_color     (bg_color_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_offset (pixel_offset),
        .pixel_color  (pixel_color),
        .on_screen    (on_screen),
        .text_row     (text_row),
        .last         (last)
    );

endmodule

`default_nettype wire

// ===== sim/text_glyph_rasterizer_top_tb.sv =====
module text_glyph_rasterizer_top_tb;
    import tgr_pkg::*;

    localparam int COL_WRAP = (LINE_WIDTH / 8 - 1 > 63) ? 63 : LINE_WIDTH / 8 - 1;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic               req;
        logic [7:0]         code;
        logic [FONT_AW-1:0] addr;
        logic [7:0]         bits;
    } request_t;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [7:0]       colour;
        logic             onscr;
        logic [7:0]       row;
        logic             is_last;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    request_t offer = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [OFF_W-1:0] pixel_offset;
    logic [7:0] pixel_color;
    logic on_screen;
    logic [7:0] text_row;
    logic last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = CFG_FG;
    logic [7:0] cfg_data = 8'd0;

    // stimulus side
    request_t pend_q[$];
    bit row_queued [0:FONT_DEPTH-1];
    bit glyph_ready [0:GLYPH_COUNT-1];
    logic [7:0] ready_codes[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req_cnt = 0;
    int hold_seen;
    int hold_left;

    // predicted block state
    logic [7:0] fg_col = FG_RESET;
    logic [7:0] bg_col = BG_RESET;
    logic [7:0] cur_row = 8'd0;
    logic [5:0] cur_col = 6'd0;
    logic [7:0] font_img [0:FONT_DEPTH-1];
    pixel_t pixel_q[$];

    pixel_t seen;
    pixel_t want;
    int err_cnt = 0;

    text_glyph_rasterizer_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (offer.req),
        .char_code     (offer.code),
        .font_row_addr (offer.addr),
        .font_row_bits (offer.bits),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_offset  (pixel_offset),
        .pixel_color   (pixel_color),
        .on_screen     (on_screen),
        .text_row      (text_row),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void next_text_row();
        if (cur_row != ROW_MAX)
            cur_row = cur_row + 8'd1;
        cur_col = 6'd0;
    endfunction

    // updates the cursor and font image and queues the pixel words one request gives
    function automatic void predict_request(input request_t r);
        int glyph;
        int x;
        int y;
        int n;
        logic [7:0] rowbits;
        pixel_t p;
        if (r.req == REQ_LOAD)
        begin
            if (r.addr < GLYPH_COUNT * 8)
                font_img[r.addr] = r.bits;
            return;
        end
        if (r.code == CODE_NEWLINE)
        begin
            next_text_row();
            return;
        end
        if (r.code < CODE_PRINTABLE)
            return;
        if (cur_col >= COL_WRAP)
            next_text_row();
        glyph = int'(r.code) - int'(CODE_PRINTABLE);
        n = 0;
        for (int cy = 0; cy < 8; cy++)
        begin
            rowbits = (glyph < GLYPH_COUNT) ? font_img[glyph * 8 + cy] : 8'd0;
            for (int cx = 0; cx < 8; cx++)
            begin
                x = int'(cur_col) * 8 + 8 - cx;
                y = int'(cur_row) * 16 + 6 + cy;
                p.offset = OFF_W'(y * LINE_WIDTH + x);
                p.colour = rowbits[cx] ? fg_col : bg_col;
                p.onscr = (y < SCREEN_HEIGHT);
                p.row = cur_row;
                p.is_last = (n == 63);
                pixel_q.push_back(p);
                n++;
            end
        end
        cur_col = cur_col + 6'd1;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_request(offer);
            if (!in_valid || in_ready)
            begin
                if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    offer <= pend_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, restarted whenever the request count moves
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_seen <= 0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_req_cnt)
        begin
            hold_seen <= hold_req_cnt;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen = '{pixel_offset, pixel_color, on_screen, text_row, last};
            if (pixel_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected pixel word: off=%0d col=%0d on=%0b row=%0d last=%0b",
                             seen.offset, seen.colour, seen.onscr, seen.row, seen.is_last);
            end
            else
            begin
                want = pixel_q.pop_front();
                if (seen.offset !== want.offset || seen.colour !== want.colour
                    || seen.onscr !== want.onscr || seen.row !== want.row
                    || seen.is_last !== want.is_last)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                    begin
                        $display("pixel mismatch: expected off=%0d col=%0d on=%0b row=%0d last=%0b",
                                 want.offset, want.colour, want.onscr, want.row, want.is_last);
                        $display("                got off=%0d col=%0d on=%0b row=%0d last=%0b",
                                 seen.offset, seen.colour, seen.onscr, seen.row, seen.is_last);
                    end
                end
            end
        end
    end

    task automatic queue_load(input int addr, input logic [7:0] bits);
        request_t r;
        int g;
        bit full;
        r.req = REQ_LOAD;
        r.code = 8'($urandom_range(255));
        r.addr = FONT_AW'(addr);
        r.bits = bits;
        pend_q.push_back(r);
        if (addr < FONT_DEPTH)
        begin
            row_queued[addr] = 1'b1;
            g = addr / 8;
            full = 1'b1;
            for (int i = 0; i < 8; i++)
                if (!row_queued[g * 8 + i])
                    full = 1'b0;
            // a code becomes printable only once all eight rows are on their way
            if (full && !glyph_ready[g])
            begin
                glyph_ready[g] = 1'b1;
                ready_codes.push_back(8'(g + CODE_PRINTABLE));
            end
        end
    endtask

    task automatic queue_char(input logic [7:0] code);
        request_t r;
        r.req = REQ_PRINT;
        r.code = code;
        r.addr = FONT_AW'($urandom_range(2047));
        r.bits = 8'($urandom_range(255));
        pend_q.push_back(r);
    endtask

    task automatic queue_known_glyph();
        queue_char(ready_codes[$urandom_range(ready_codes.size() - 1)]);
    endtask

    task automatic random_items(input int count);
        int pick;
        int g;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                g = $urandom_range(GLYPH_COUNT - 1);
                for (int i = 0; i < 8; i++)
                    queue_load(g * 8 + i, 8'($urandom_range(255)));
            end
            else if (pick < 20)
                queue_load($urandom_range(2047), 8'($urandom_range(255)));
            else if (pick < 24)
                queue_char(CODE_NEWLINE);
            else if (pick < 28)
                queue_char(8'($urandom_range(31)));
            else
                queue_known_glyph();
        end
    endtask

    task automatic wait_drained();
        // checked between edges, where a word just popped already shows as offered
        do
            @(negedge clk);
        while (pend_q.size() != 0 || in_valid || pixel_q.size() != 0);
        // a font load gives no word but may still be in the pipeline
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_FG)
            fg_col = val;
        else
            bg_col = val;
    endtask

    initial
    begin
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: glyphs for the lowest and highest codes, out-of-range loads,
        // control codes and newline, all at reset colours
        queue_load(1784, 8'hFF);
        queue_load(1785, 8'h00);
        queue_load(1786, 8'h81);
        queue_load(1787, 8'h7E);
        queue_load(1788, 8'h01);
        queue_load(1789, 8'h80);
        queue_load(1790, 8'h55);
        queue_load(1791, 8'hAA);
        queue_load(0, 8'h00);
        queue_load(1, 8'hFF);
        queue_load(2, 8'h0F);
        queue_load(3, 8'hF0);
        queue_load(4, 8'h3C);
        queue_load(5, 8'hC3);
        queue_load(6, 8'h18);
        queue_load(7, 8'hE7);
        queue_load(2047, 8'hFF);
        queue_load(1792, 8'h00);
        queue_char(8'd255);
        queue_char(CODE_PRINTABLE);
        queue_char(8'd0);
        queue_char(8'd31);
        queue_char(CODE_NEWLINE);
        queue_char(8'd255);
        wait_drained();

        // long line to force a column wrap, sender mostly idle
        write_reg(CFG_FG, 8'hFF);
        write_reg(CFG_BG, 8'h00);
        send_idle_pct <= 83;
        for (int i = 0; i < 40; i++)
            queue_known_glyph();
        random_items(3);
        wait_drained();

        // receiver mostly stalling, then a long hold-off to back up the input
        write_reg(CFG_FG, 8'h00);
        write_reg(CFG_BG, 8'hFF);
        send_idle_pct <= 0;
        recv_stall_pct <= 83;
        random_items(5);
        hold_req_cnt <= hold_req_cnt + 1;
        for (int i = 0; i < 6; i++)
            queue_known_glyph();
        random_items(2);
        wait_drained();

        write_reg(CFG_FG, 8'($urandom_range(255)));
        write_reg(CFG_BG, 8'($urandom_range(255)));
        send_idle_pct <= 38;
        recv_stall_pct <= 38;
        random_items(6);
        wait_drained();
        random_items(4);
        wait_drained();

        // screen bottom edge at rows 11 and 12
        write_reg(CFG_FG, 8'h5A);
        write_reg(CFG_BG, 8'hA5);
        send_idle_pct <= 0;
        recv_stall_pct <= 0;
        k = (cur_row < 8'd10) ? 10 - int'(cur_row) : 0;
        repeat (k + 1) queue_char(CODE_NEWLINE);
        queue_known_glyph();
        queue_known_glyph();
        queue_char(CODE_NEWLINE);
        queue_known_glyph();
        queue_known_glyph();
        wait_drained();
        repeat (20) @(posedge clk);

        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
